>>> hw/rtl/tpct_pkg.sv
// Shared types, constants and the control program of the triple product tensor block.
// Used by tpct_store, tpct_seq, tpct_dp and the top level; depends on nothing else.

package tpct_pkg;

	// Default sizes, handed to the top level parameters
	localparam int unsigned MAX_POINTS_DEF = 256;
	localparam int unsigned MAX_RANK_DEF   = 4;

	// Fixed field widths
	localparam int unsigned ELEM_W    = 16;
	localparam int unsigned WEIGHT_W  = 16;
	localparam int unsigned COEF_W    = 55;
	localparam int unsigned IDX_W     = 2;
	localparam int unsigned PTS_W     = 9;
	localparam int unsigned COLS_W    = 3;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DAT_W = 16;
	localparam int unsigned CHUNK_W   = 16;

	// Item request codes
	typedef enum logic [1:0] {
		REQ_FIRST   = 2'd0,
		REQ_SECOND  = 2'd1,
		REQ_THIRD   = 2'd2,
		REQ_COMPUTE = 2'd3
	} req_t;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_POINTS      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COLS_FIRST  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COLS_SECOND = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_COLS_THIRD  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT      = 3'd4;

	// Program steps
	localparam int unsigned STEP_W = 4;
	typedef logic [STEP_W-1:0] step_t;
	localparam step_t STEP_IDLE  = 4'd0;
	localparam step_t STEP_CLR   = 4'd1;
	localparam step_t STEP_PTS   = 4'd2;
	localparam step_t STEP_DRAIN = 4'd3;
	localparam step_t STEP_SINIT = 4'd4;
	localparam step_t STEP_SMUL  = 4'd5;
	localparam step_t STEP_SADD  = 4'd6;
	localparam step_t STEP_EMIT  = 4'd7;
	localparam step_t STEP_ADV   = 4'd8;

	// Branch conditions
	typedef enum logic [2:0] {
		COND_ALWAYS = 3'd0,
		COND_START  = 3'd1,
		COND_PMORE  = 3'd2,
		COND_PBUSY  = 3'd3,
		COND_CMORE  = 3'd4,
		COND_OBUSY  = 3'd5,
		COND_LAST   = 3'd6
	} cond_t;

	// One control word
	typedef struct packed {
		cond_t cond;
		step_t nxt_t;
		step_t nxt_f;
		logic  in_rdy;
		logic  idx_clr;
		logic  acc_clr;
		logic  issue;
		logic  sc_init;
		logic  sc_mul;
		logic  sc_add;
		logic  emit;
		logic  adv;
	} ctrl_t;

	// Datapath status seen by the sequencer
	typedef struct packed {
		logic start;
		logic p_more;
		logic p_busy;
		logic c_more;
		logic o_busy;
		logic last;
	} stat_t;

	// Control program ROM
	function automatic ctrl_t ucode(input step_t s);
		ctrl_t w;
		w = '0;
		w.cond  = COND_ALWAYS;
		w.nxt_t = STEP_IDLE;
		w.nxt_f = STEP_IDLE;
		case (s)
			STEP_IDLE: begin
				w.in_rdy  = 1'b1;
				w.idx_clr = 1'b1;
				w.cond    = COND_START;
				w.nxt_t   = STEP_CLR;
				w.nxt_f   = STEP_IDLE;
			end
			STEP_CLR: begin
				w.acc_clr = 1'b1;
				w.nxt_t   = STEP_PTS;
			end
			STEP_PTS: begin
				w.issue = 1'b1;
				w.cond  = COND_PMORE;
				w.nxt_t = STEP_PTS;
				w.nxt_f = STEP_DRAIN;
			end
			STEP_DRAIN: begin
				w.cond  = COND_PBUSY;
				w.nxt_t = STEP_DRAIN;
				w.nxt_f = STEP_SINIT;
			end
			STEP_SINIT: begin
				w.sc_init = 1'b1;
				w.nxt_t   = STEP_SMUL;
			end
			STEP_SMUL: begin
				w.sc_mul = 1'b1;
				w.nxt_t  = STEP_SADD;
			end
			STEP_SADD: begin
				w.sc_add = 1'b1;
				w.cond   = COND_CMORE;
				w.nxt_t  = STEP_SMUL;
				w.nxt_f  = STEP_EMIT;
			end
			STEP_EMIT: begin
				w.emit  = 1'b1;
				w.cond  = COND_OBUSY;
				w.nxt_t = STEP_EMIT;
				w.nxt_f = STEP_ADV;
			end
			STEP_ADV: begin
				w.adv   = 1'b1;
				w.cond  = COND_LAST;
				w.nxt_t = STEP_IDLE;
				w.nxt_f = STEP_CLR;
			end
			default: begin
				w.nxt_t = STEP_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

>>> hw/rtl/tpct_store.sv
// One matrix store: single write port, single read port, registered read data.
// Depends on tpct_pkg for the element width.

module tpct_store #(
	parameter int unsigned DEPTH = tpct_pkg::MAX_POINTS_DEF * tpct_pkg::MAX_RANK_DEF
) (
	input  logic                           clk,
	input  logic                           we,
	input  logic [$clog2(DEPTH)-1:0]       waddr,
	input  logic [tpct_pkg::ELEM_W-1:0]    wdata,
	input  logic [$clog2(DEPTH)-1:0]       raddr,
	output logic [tpct_pkg::ELEM_W-1:0]    rdata
);

	logic [tpct_pkg::ELEM_W-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, data registered
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

>>> hw/rtl/tpct_seq.sv
// Microcode sequencer: step counter, program ROM lookup and branch logic.
// Depends on tpct_pkg for the control word, status struct and program.

module tpct_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  tpct_pkg::stat_t stat,
	output tpct_pkg::ctrl_t ctrl
);

	tpct_pkg::step_t step_q;
	tpct_pkg::step_t step_d;
	logic            hit;

	// current control word
	assign ctrl = tpct_pkg::ucode(step_q);

	// branch condition select
	always_comb begin
		case (ctrl.cond)
			tpct_pkg::COND_ALWAYS: hit = 1'b1;
			tpct_pkg::COND_START:  hit = stat.start;
			tpct_pkg::COND_PMORE:  hit = stat.p_more;
			tpct_pkg::COND_PBUSY:  hit = stat.p_busy;
			tpct_pkg::COND_CMORE:  hit = stat.c_more;
			tpct_pkg::COND_OBUSY:  hit = stat.o_busy;
			tpct_pkg::COND_LAST:   hit = stat.last;
			default:               hit = 1'b1;
		endcase
		step_d = hit ? ctrl.nxt_t : ctrl.nxt_f;
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= tpct_pkg::STEP_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

endmodule

>>> hw/rtl/tpct_dp.sv
// Datapath: point and index counters, store addressing, triple product MAC pipeline,
// chunked weight scaler and the result register. Depends on tpct_pkg.

module tpct_dp #(
	parameter int unsigned MAX_POINTS = tpct_pkg::MAX_POINTS_DEF,
	parameter int unsigned MAX_RANK   = tpct_pkg::MAX_RANK_DEF,
	localparam int unsigned PW = $clog2(MAX_POINTS),
	localparam int unsigned RW = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1,
	localparam int unsigned AW = $clog2(MAX_POINTS * MAX_RANK)
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  tpct_pkg::ctrl_t                      ctrl,
	input  logic                                 start,
	input  logic [PW-1:0]                        last_p,
	input  logic [RW-1:0]                        ni_m1,
	input  logic [RW-1:0]                        nj_m1,
	input  logic [RW-1:0]                        nk_m1,
	input  logic [tpct_pkg::WEIGHT_W-1:0]        weight,
	input  logic [tpct_pkg::ELEM_W-1:0]          rd_first,
	input  logic [tpct_pkg::ELEM_W-1:0]          rd_second,
	input  logic [tpct_pkg::ELEM_W-1:0]          rd_third,
	output logic [AW-1:0]                        raddr_first,
	output logic [AW-1:0]                        raddr_second,
	output logic [AW-1:0]                        raddr_third,
	output tpct_pkg::stat_t                      stat,
	output logic                                 coef_valid,
	input  logic                                 coef_stall,
	output logic [tpct_pkg::IDX_W-1:0]           index_i,
	output logic [tpct_pkg::IDX_W-1:0]           index_j,
	output logic [tpct_pkg::IDX_W-1:0]           index_k,
	output logic signed [tpct_pkg::COEF_W-1:0]   coefficient,
	output logic                                 last
);

	localparam int unsigned AB_W      = 2 * tpct_pkg::ELEM_W;
	localparam int unsigned TRI_W     = 3 * tpct_pkg::ELEM_W;
	localparam int unsigned ACC_W     = TRI_W + $clog2(MAX_POINTS);
	localparam int unsigned CHUNKS    = (ACC_W + tpct_pkg::CHUNK_W - 1) / tpct_pkg::CHUNK_W;
	localparam int unsigned CW        = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
	localparam int unsigned PP_W      = 2 * (tpct_pkg::CHUNK_W + 1);
	localparam int unsigned PROD_W    = CHUNKS * tpct_pkg::CHUNK_W + tpct_pkg::WEIGHT_W;
	localparam int unsigned OUT_TOP   = tpct_pkg::COEF_W + tpct_pkg::WEIGHT_W;
	localparam int unsigned SCALE_W   = (PROD_W > OUT_TOP) ? PROD_W : OUT_TOP;
	localparam int unsigned ROUND_BIT = tpct_pkg::WEIGHT_W - 1;

	// counters
	logic [PW-1:0] p_q;
	logic [RW-1:0] i_q;
	logic [RW-1:0] j_q;
	logic [RW-1:0] k_q;

	// MAC pipeline
	logic                        v_s1;
	logic                        v_s2;
	logic                        v_s3;
	logic signed [AB_W-1:0]      ab_s2;
	logic signed [tpct_pkg::ELEM_W-1:0] c_s2;
	logic signed [TRI_W-1:0]     tri_s3;
	logic signed [ACC_W-1:0]     acc_q;

	// scaler
	logic [CHUNKS-1:0][tpct_pkg::CHUNK_W-1:0] acc_chunks;
	logic [tpct_pkg::CHUNK_W-1:0] chunk;
	logic                         chunk_top;
	logic signed [tpct_pkg::CHUNK_W:0] chunk_op;
	logic [CW-1:0]                cidx_q;
	logic signed [PP_W-1:0]       pp_q;
	logic signed [SCALE_W-1:0]    sacc_q;
	logic signed [SCALE_W-1:0]    rnd;

	// result register
	logic                         coef_valid_q;
	logic                         o_busy;
	logic                         is_last;
	logic                         load_out;

	// point counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q <= '0;
		end else if (ctrl.acc_clr) begin
			p_q <= '0;
		end else if (ctrl.issue) begin
			p_q <= p_q + 1'b1;
		end
	end

	// coefficient index counters, i innermost
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
		end else if (ctrl.idx_clr) begin
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
		end else if (ctrl.adv) begin
			if (i_q == ni_m1) begin
				i_q <= '0;
				if (j_q == nj_m1) begin
					j_q <= '0;
					k_q <= (k_q == nk_m1) ? '0 : k_q + 1'b1;
				end else begin
					j_q <= j_q + 1'b1;
				end
			end else begin
				i_q <= i_q + 1'b1;
			end
		end
	end

	assign is_last = (i_q == ni_m1) && (j_q == nj_m1) && (k_q == nk_m1);

	// store addresses: row-major, MAX_RANK entries per point
	assign raddr_first  = AW'(AW'(p_q) * AW'(MAX_RANK) + AW'(i_q));
	assign raddr_second = AW'(AW'(p_q) * AW'(MAX_RANK) + AW'(j_q));
	assign raddr_third  = AW'(AW'(p_q) * AW'(MAX_RANK) + AW'(k_q));

	// pipeline valids; stage 1 is the store read register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= ctrl.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// first product, then times the third element
	always_ff @(posedge clk) begin
		ab_s2  <= $signed(rd_first) * $signed(rd_second);
		c_s2   <= $signed(rd_third);
		tri_s3 <= TRI_W'(ab_s2 * c_s2);
	end

	// exact sum of triple products
	always_ff @(posedge clk) begin
		if (ctrl.acc_clr) begin
			acc_q <= '0;
		end else if (v_s3) begin
			acc_q <= acc_q + ACC_W'(tri_s3);
		end
	end

	// sum times weight, 16-bit chunk per pass, top chunk signed
	assign acc_chunks = (CHUNKS * tpct_pkg::CHUNK_W)'(acc_q);
	assign chunk      = acc_chunks[cidx_q];
	assign chunk_top  = (cidx_q == CW'(CHUNKS - 1));
	assign chunk_op   = $signed({chunk_top & chunk[tpct_pkg::CHUNK_W-1], chunk});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cidx_q <= '0;
		end else if (ctrl.sc_init) begin
			cidx_q <= CW'(CHUNKS - 1);
		end else if (ctrl.sc_add) begin
			cidx_q <= cidx_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.sc_mul) begin
			pp_q <= chunk_op * $signed({1'b0, weight});
		end
		if (ctrl.sc_init) begin
			sacc_q <= '0;
		end else if (ctrl.sc_add) begin
			sacc_q <= (sacc_q <<< tpct_pkg::CHUNK_W) + SCALE_W'(pp_q);
		end
	end

	// round half up and drop the weight fraction
	assign rnd = sacc_q + $signed(SCALE_W'(1) << ROUND_BIT);

	// result register
	assign o_busy   = coef_valid_q && coef_stall;
	assign load_out = ctrl.emit && !o_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_valid_q <= 1'b0;
		end else if (load_out) begin
			coef_valid_q <= 1'b1;
		end else if (!coef_stall) begin
			coef_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			index_i     <= tpct_pkg::IDX_W'(i_q);
			index_j     <= tpct_pkg::IDX_W'(j_q);
			index_k     <= tpct_pkg::IDX_W'(k_q);
			coefficient <= rnd[tpct_pkg::WEIGHT_W +: tpct_pkg::COEF_W];
			last        <= is_last;
		end
	end

	assign coef_valid = coef_valid_q;

	// status to the sequencer
	always_comb begin
		stat        = '0;
		stat.start  = start;
		stat.p_more = (p_q != last_p);
		stat.p_busy = v_s1 || v_s2 || v_s3;
		stat.c_more = (cidx_q != '0);
		stat.o_busy = o_busy;
		stat.last   = is_last;
	end

	// the MAC pipeline is empty whenever a result is formed
	a_emit_drained: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.emit |-> !(v_s1 || v_s2 || v_s3))
		else $error("result formed with products still in flight");

	// no product is dropped by clearing the sum
	a_clr_no_loss: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.acc_clr |-> !v_s3)
		else $error("sum cleared while a product arrives");

	// reads never run past the configured point count
	a_issue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.issue |-> (p_q <= last_p))
		else $error("point index past the last point");

	// a loaded result carries the last flag of the index it was formed at
	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> (coef_valid_q && (last == $past(is_last))))
		else $error("result register not loaded as expected");

endmodule

>>> hw/rtl/triple_product_coefficient_tensor.sv
// Top level of the weighted triple product coefficient tensor.
// Depends on tpct_pkg, tpct_store, tpct_seq and tpct_dp.
//
// channel  dir  handshake                 payload
// item     in   item_valid / item_stall   req_type, row, col, elem_value
// coef     out  coef_valid / coef_stall   index_i, index_j, index_k, coefficient, last
// cfg      in   cfg_valid / cfg_ready     cfg_index, cfg_data
//
// Load items are accepted back to back while idle.
// Once a compute item is accepted, item_stall stays high until the program returns to
// its idle step, after the advance step that follows the load of its last coefficient
// into the result register. Each coefficient is formed by the one-point-per-cycle MAC
// loop and then the chunked scaling loop (4 chunks of the weight multiply at default
// sizes); a stalled result register holds the program at its emit step. Reset clears
// control and presets the configuration only; the stores hold nothing until written.

module triple_product_coefficient_tensor #(
	parameter int unsigned MAX_POINTS = tpct_pkg::MAX_POINTS_DEF,
	parameter int unsigned MAX_RANK   = tpct_pkg::MAX_RANK_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// item channel
	input  logic                                  item_valid,
	output logic                                  item_stall,
	input  logic [1:0]                            req_type,
	input  logic [7:0]                            row,
	input  logic [1:0]                            col,
	input  logic signed [tpct_pkg::ELEM_W-1:0]    elem_value,
	// result channel
	output logic                                  coef_valid,
	input  logic                                  coef_stall,
	output logic [tpct_pkg::IDX_W-1:0]            index_i,
	output logic [tpct_pkg::IDX_W-1:0]            index_j,
	output logic [tpct_pkg::IDX_W-1:0]            index_k,
	output logic signed [tpct_pkg::COEF_W-1:0]    coefficient,
	output logic                                  last,
	// configuration channel
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [tpct_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [tpct_pkg::CFG_DAT_W-1:0]        cfg_data
);

	localparam int unsigned DEPTH = MAX_POINTS * MAX_RANK;
	localparam int unsigned PW    = $clog2(MAX_POINTS);
	localparam int unsigned RW    = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
	localparam int unsigned AW    = $clog2(DEPTH);

	// configuration registers
	logic [tpct_pkg::PTS_W-1:0]    cfg_points_q;
	logic [tpct_pkg::COLS_W-1:0]   cfg_cols_first_q;
	logic [tpct_pkg::COLS_W-1:0]   cfg_cols_second_q;
	logic [tpct_pkg::COLS_W-1:0]   cfg_cols_third_q;
	logic [tpct_pkg::WEIGHT_W-1:0] cfg_weight_q;

	// clamped loop limits
	logic [PW-1:0] last_p;
	logic [RW-1:0] ni_m1;
	logic [RW-1:0] nj_m1;
	logic [RW-1:0] nk_m1;

	// item handling
	logic          item_acc;
	logic          wr_ok;
	logic          start;
	logic [AW-1:0] waddr;
	logic          we_first;
	logic          we_second;
	logic          we_third;

	// store read side
	logic [AW-1:0]                 raddr_first;
	logic [AW-1:0]                 raddr_second;
	logic [AW-1:0]                 raddr_third;
	logic [tpct_pkg::ELEM_W-1:0]   rd_first;
	logic [tpct_pkg::ELEM_W-1:0]   rd_second;
	logic [tpct_pkg::ELEM_W-1:0]   rd_third;

	tpct_pkg::ctrl_t ctrl;
	tpct_pkg::stat_t stat;

	// column count clamp: zero reads as one, saturate at MAX_RANK; gives count - 1
	function automatic logic [RW-1:0] rank_m1(input logic [tpct_pkg::COLS_W-1:0] v);
		logic [RW-1:0] r;
		if (v == '0) begin
			r = '0;
		end else if (32'(v) > MAX_RANK) begin
			r = RW'(MAX_RANK - 1);
		end else begin
			r = RW'(v - 1'b1);
		end
		return r;
	endfunction

	// configuration writes, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_points_q      <= 9'd256;
			cfg_cols_first_q  <= 3'd4;
			cfg_cols_second_q <= 3'd4;
			cfg_cols_third_q  <= 3'd4;
			cfg_weight_q      <= 16'hFFFF;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				tpct_pkg::CFG_POINTS:      cfg_points_q      <= cfg_data[tpct_pkg::PTS_W-1:0];
				tpct_pkg::CFG_COLS_FIRST:  cfg_cols_first_q  <= cfg_data[tpct_pkg::COLS_W-1:0];
				tpct_pkg::CFG_COLS_SECOND: cfg_cols_second_q <= cfg_data[tpct_pkg::COLS_W-1:0];
				tpct_pkg::CFG_COLS_THIRD:  cfg_cols_third_q  <= cfg_data[tpct_pkg::COLS_W-1:0];
				tpct_pkg::CFG_WEIGHT:      cfg_weight_q      <= cfg_data[tpct_pkg::WEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	// point count clamp
	always_comb begin
		if (cfg_points_q == '0) begin
			last_p = '0;
		end else if (32'(cfg_points_q) > MAX_POINTS) begin
			last_p = PW'(MAX_POINTS - 1);
		end else begin
			last_p = PW'(cfg_points_q - 1'b1);
		end
	end

	assign ni_m1 = rank_m1(cfg_cols_first_q);
	assign nj_m1 = rank_m1(cfg_cols_second_q);
	assign nk_m1 = rank_m1(cfg_cols_third_q);

	// item decode: element loads write a store, compute starts the program
	assign item_stall = !ctrl.in_rdy;
	assign item_acc   = item_valid && !item_stall;
	assign wr_ok      = (32'(row) < MAX_POINTS) && (32'(col) < MAX_RANK);
	assign waddr      = AW'(AW'(row) * AW'(MAX_RANK) + AW'(col));
	assign we_first   = item_acc && wr_ok && (req_type == tpct_pkg::REQ_FIRST);
	assign we_second  = item_acc && wr_ok && (req_type == tpct_pkg::REQ_SECOND);
	assign we_third   = item_acc && wr_ok && (req_type == tpct_pkg::REQ_THIRD);
	assign start      = item_acc && (req_type == tpct_pkg::REQ_COMPUTE);

	tpct_store #(.DEPTH(DEPTH)) u_store_first (
		.clk   (clk),
		.we    (we_first),
		.waddr (waddr),
		.wdata (elem_value),
		.raddr (raddr_first),
		.rdata (rd_first)
	);

	tpct_store #(.DEPTH(DEPTH)) u_store_second (
		.clk   (clk),
		.we    (we_second),
		.waddr (waddr),
		.wdata (elem_value),
		.raddr (raddr_second),
		.rdata (rd_second)
	);

	tpct_store #(.DEPTH(DEPTH)) u_store_third (
		.clk   (clk),
		.we    (we_third),
		.waddr (waddr),
		.wdata (elem_value),
		.raddr (raddr_third),
		.rdata (rd_third)
	);

	tpct_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	tpct_dp #(
		.MAX_POINTS (MAX_POINTS),
		.MAX_RANK   (MAX_RANK)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.start        (start),
		.last_p       (last_p),
		.ni_m1        (ni_m1),
		.nj_m1        (nj_m1),
		.nk_m1        (nk_m1),
		.weight       (cfg_weight_q),
		.rd_first     (rd_first),
		.rd_second    (rd_second),
		.rd_third     (rd_third),
		.raddr_first  (raddr_first),
		.raddr_second (raddr_second),
		.raddr_third  (raddr_third),
		.stat         (stat),
		.coef_valid   (coef_valid),
		.coef_stall   (coef_stall),
		.index_i      (index_i),
		.index_j      (index_j),
		.index_k      (index_k),
		.coefficient  (coefficient),
		.last         (last)
	);

endmodule
